>>> sv/sine_range_reduced_series_unit_macros.svh
// assertion macros for the sine series unit
`ifndef SINE_RANGE_REDUCED_SERIES_UNIT_MACROS_SVH
`define SINE_RANGE_REDUCED_SERIES_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SRS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked in the same cycle
`define SRS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/srs_pkg.sv
// shared constants and the pipeline item type for the sine series unit
package srs_pkg;

    localparam int MAX_TERMS_DEF     = 16;
    localparam int OUT_FRAC_BITS_DEF = 30;
    localparam int IN_FRAC_BITS_DEF  = 24;
    localparam int WORK_FRAC         = 30;
    localparam int THR_WIDTH         = 16;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1074;

    // pi scaled by 2^62, truncated
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

    // reciprocal scaling for division by n*(n-1)
    localparam int RECIP_SHIFT = 46;
    localparam int RECIP_HALF  = 22;

    localparam logic [7:0] REG_TERM_THRESHOLD = 8'd0;

    typedef struct packed {
        logic [31:0]        tm;
        logic [31:0]        x2;
        logic signed [35:0] sum;
        logic [5:0]         count;
        logic               neg;
    } srs_item_t;

endpackage

>>> sv/sine_range_reduced_series_unit.sv
// top level of the sine series unit: config port, pipeline chain, output stage
//
//  channel   dir  fields
//  s_axis    in   tdata: angle[31:0]
//  m_axis    out  tdata: sine_value[31:0], terms_used[36:32], term_limit_hit[37]
//  apb       in   reg 0 term_threshold at byte address 0
//
// one word enters per cycle when the output side is not stalled
// the pipeline holds one compare-subtract stage per quotient bit
// and four stages per term
// a stalled output word freezes the whole pipeline, nothing is dropped
// reset clears valid bits and loads the threshold with its reset value
`include "sine_range_reduced_series_unit_macros.svh"
module sine_range_reduced_series_unit #(
    parameter int MAX_TERMS     = srs_pkg::MAX_TERMS_DEF,
    parameter int OUT_FRAC_BITS = srs_pkg::OUT_FRAC_BITS_DEF,
    parameter int IN_FRAC_BITS  = srs_pkg::IN_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // angle[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // sine_value[31:0], terms_used[36:32], term_limit_hit[37]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TSH = srs_pkg::WORK_FRAC - OUT_FRAC_BITS;
    localparam logic [63:0] RND = (64'd1 << TSH) >> 1;
    localparam logic [30:0] ONE = 31'd1 << srs_pkg::WORK_FRAC;

    logic [srs_pkg::THR_WIDTH-1:0] thr_reg;
    logic [31:0]                   thr;
    logic                          en;

    logic               vld [0:MAX_TERMS-1];
    srs_pkg::srs_item_t itm [0:MAX_TERMS-1];

    logic        f_vld_reg, f_neg_reg, f_hit_reg;
    logic [30:0] f_res_reg;
    logic [5:0]  f_cnt_reg;
    logic        o_vld_reg;
    logic [31:0] o_val_reg;
    logic [4:0]  o_cnt_reg;
    logic        o_hit_reg;
    logic [63:0] rounded;
    logic        reg_sel;
    srs_pkg::srs_item_t last;

    // config port
    assign pready  = 1'b1;
    assign reg_sel = {5'd0, paddr[2]} == srs_pkg::REG_TERM_THRESHOLD[5:0];
    assign prdata  = reg_sel ? {16'd0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= srs_pkg::THR_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            thr_reg <= pwdata[15:0];
        end
    end

    assign thr      = 32'(thr_reg) << TSH;
    assign en       = !o_vld_reg || m_tready;
    assign s_tready = en;

    srs_reduce #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .angle    (s_tdata),
        .out_valid(vld[0]),
        .out_item (itm[0])
    );

    for (genvar j = 1; j < MAX_TERMS; j++)
    begin : g_term
        srs_term #(
            .STEP(j)
        ) u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .thr      (thr),
            .in_valid (vld[j-1]),
            .in_item  (itm[j-1]),
            .out_valid(vld[j]),
            .out_item (itm[j])
        );
    end

    assign last    = itm[MAX_TERMS-1];
    assign rounded = (64'(f_res_reg) + RND) >> TSH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= vld[MAX_TERMS-1];
            o_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // clamp to [0, 1.0]
            if (last.sum < 36'sd0)
            begin
                f_res_reg <= 31'd0;
            end
            else if (last.sum > signed'(36'(ONE)))
            begin
                f_res_reg <= ONE;
            end
            else
            begin
                f_res_reg <= last.sum[30:0];
            end
            f_neg_reg <= last.neg;
            f_hit_reg <= last.tm >= thr;
            f_cnt_reg <= last.count;
            o_val_reg <= f_neg_reg ? (~rounded[31:0] + 32'd1) : rounded[31:0];
            o_cnt_reg <= f_cnt_reg[4:0];
            o_hit_reg <= f_hit_reg;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {2'b00, o_hit_reg, o_cnt_reg, o_val_reg};

    `SRS_ASSERT_IMPL(a_count_range, f_vld_reg,
        (f_cnt_reg >= 6'd1) && (f_cnt_reg <= 6'(MAX_TERMS)), "term count out of range")
    `SRS_ASSERT_IMPL(a_hit_at_limit, f_vld_reg && f_hit_reg,
        f_cnt_reg == 6'(MAX_TERMS), "limit flag before last term")
    `SRS_ASSERT_IMPL(a_clamped, f_vld_reg, f_res_reg <= ONE, "magnitude above one")

endmodule

>>> sv/srs_reduce.sv
// range reduction of the angle and the first series term
module srs_reduce #(
    parameter int IN_FRAC_BITS = srs_pkg::IN_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       angle,
    output logic              out_valid,
    output srs_pkg::srs_item_t out_item
);

    localparam int QBITS = 29 - IN_FRAC_BITS;
    localparam int SH    = IN_FRAC_BITS + 2;
    localparam logic [63:0] PI_R      = srs_pkg::PI_Q62 >> (30 - IN_FRAC_BITS);
    localparam logic [63:0] TWO_PI_R  = srs_pkg::PI_Q62 >> (29 - IN_FRAC_BITS);
    localparam logic [63:0] HALF_PI_R = srs_pkg::PI_Q62 >> (31 - IN_FRAC_BITS);
    localparam logic [63:0] RND       = 64'd1 << (SH - 1);

    logic [63:0] rem_reg [0:QBITS];
    logic        neg_reg [0:QBITS];
    logic        vld_reg [0:QBITS];

    logic [31:0] mag;
    logic [63:0] f_rem_reg, m_rem_reg;
    logic        f_neg_reg, m_neg_reg, r_neg_reg, q_neg_reg;
    logic        f_vld_reg, m_vld_reg, r_vld_reg, q_vld_reg, o_vld_reg;
    logic [31:0] x_reg, qx_reg;
    logic [63:0] sq_reg;
    logic [63:0] x2_full;
    logic [63:0] x_full;
    srs_pkg::srs_item_t item_reg;

    assign mag = angle[31] ? (~angle + 32'd1) : angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {mag, 32'd0};
            neg_reg[0] <= angle[31];
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QBITS; k++)
    begin : g_mod
        localparam logic [63:0] DIV = TWO_PI_R << (QBITS - 1 - k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= (rem_reg[k] >= DIV) ? (rem_reg[k] - DIV) : rem_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign x_full  = 64'(x_reg);
    assign x2_full = (sq_reg + (64'd1 << (srs_pkg::WORK_FRAC - 1))) >> srs_pkg::WORK_FRAC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= vld_reg[QBITS];
            m_vld_reg <= f_vld_reg;
            r_vld_reg <= m_vld_reg;
            q_vld_reg <= r_vld_reg;
            o_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // upper half-period folds with a sign flip
            if (rem_reg[QBITS] > PI_R)
            begin
                f_rem_reg <= rem_reg[QBITS] - PI_R;
                f_neg_reg <= !neg_reg[QBITS];
            end
            else
            begin
                f_rem_reg <= rem_reg[QBITS];
                f_neg_reg <= neg_reg[QBITS];
            end
            m_rem_reg <= (f_rem_reg > HALF_PI_R) ? (PI_R - f_rem_reg) : f_rem_reg;
            m_neg_reg <= f_neg_reg;
            x_reg     <= 32'((m_rem_reg + RND) >> SH);
            r_neg_reg <= m_neg_reg;
            sq_reg    <= x_full * x_full;
            qx_reg    <= x_reg;
            q_neg_reg <= r_neg_reg;
            item_reg.tm    <= qx_reg;
            item_reg.x2    <= x2_full[31:0];
            item_reg.sum   <= signed'(36'(qx_reg));
            item_reg.count <= 6'd1;
            item_reg.neg   <= q_neg_reg;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_item  = item_reg;

endmodule

>>> sv/srs_term.sv
// one series term: multiply by x squared, divide by n*(n-1), accumulate
module srs_term #(
    parameter int STEP = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [31:0]        thr,
    input  logic               in_valid,
    input  srs_pkg::srs_item_t in_item,
    output logic               out_valid,
    output srs_pkg::srs_item_t out_item
);

    localparam longint unsigned N    = 2 * STEP + 1;
    localparam longint unsigned D    = N * (N - 1);
    localparam longint unsigned M    = ((64'd1 << srs_pkg::RECIP_SHIFT) + D - 1) / D;
    localparam logic [63:0]     MHI  = 64'(M >> srs_pkg::RECIP_HALF);
    localparam logic [63:0]     MLO  = 64'(M) & ((64'd1 << srs_pkg::RECIP_HALF) - 64'd1);
    localparam logic [63:0]     HALF = 64'(D / 2);
    localparam bit              SUBTRACT = (STEP % 2) == 1;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               a1_reg, a2_reg, a3_reg;
    srs_pkg::srs_item_t i1_reg, i2_reg, i3_reg, i4_reg;
    logic [63:0]        p_reg, v_reg, ph_reg, pl_reg;
    logic [63:0]        q;
    logic signed [35:0] q_s;

    // high partial product is taken at its own weight so the sum stays inside 64 bits
    assign q   = (ph_reg + (pl_reg >> srs_pkg::RECIP_HALF))
                 >> (srs_pkg::RECIP_SHIFT - srs_pkg::RECIP_HALF);
    assign q_s = signed'(36'(q[31:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a term below threshold stays, so later stages stay idle too
            a1_reg <= in_item.tm >= thr;
            p_reg  <= 64'(in_item.tm) * 64'(in_item.x2);
            i1_reg <= in_item;
            a2_reg <= a1_reg;
            v_reg  <= ((p_reg + (64'd1 << (srs_pkg::WORK_FRAC - 1))) >> srs_pkg::WORK_FRAC)
                      + HALF;
            i2_reg <= i1_reg;
            a3_reg <= a2_reg;
            ph_reg <= v_reg * MHI;
            pl_reg <= v_reg * MLO;
            i3_reg <= i2_reg;
            if (a3_reg)
            begin
                i4_reg.tm    <= q[31:0];
                i4_reg.x2    <= i3_reg.x2;
                i4_reg.sum   <= SUBTRACT ? (i3_reg.sum - q_s) : (i3_reg.sum + q_s);
                i4_reg.count <= i3_reg.count + 6'd1;
                i4_reg.neg   <= i3_reg.neg;
            end
            else
            begin
                i4_reg <= i3_reg;
            end
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = i4_reg;

endmodule

>>> sim/sine_range_reduced_series_unit_tb.sv
// testbench for the sine series unit: directed table, random angles, predicted results
`timescale 1ns / 100ps

module sine_range_reduced_series_unit_tb;

    localparam int MAX_TERMS     = 16;
    localparam int OUT_FRAC      = 30;
    localparam int IN_FRAC       = 24;
    localparam int WORK_FRAC     = 30;
    localparam int RED_FRAC      = IN_FRAC + 32;
    localparam int LATENCY       = (29 - IN_FRAC) + 8 + 4 * (MAX_TERMS - 1);
    localparam int N_RANDOM      = 780;
    localparam longint CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic        limit_hit;
        logic [4:0]  terms;
        logic [31:0] sine;
    } sine_word_t;

    typedef struct {
        logic [31:0] angle;
        logic        known;
        sine_word_t  result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // angle[31:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // sine_value[31:0], terms_used[36:32], term_limit_hit[37]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sine_range_reduced_series_unit DUT (.*);

    logic [15:0] threshold;
    sine_word_t  sine_queue[$];
    int          errors;
    int          words_out;
    longint      cycles;
    logic        hold_off;
    int          hold_off_len;
    stim_row_t   directed[$];

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] round_down(logic [127:0] v, int sh);
        logic [127:0] r;
        r = (v + (128'd1 << (sh - 1))) >> sh;
        return r[63:0];
    endfunction

    // range reduction then alternating series, all in fixed point
    function automatic sine_word_t predict_sine(logic [31:0] angle, logic [15:0] thr_cfg);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] pi_r, two_pi_r, half_pi_r, xr, x, x2, tm, d, nn, thr, res;
        logic signed [63:0] acc;
        logic        positive;
        int          count;
        sine_word_t  w;
        neg       = angle[31];
        mag       = neg ? (~angle + 32'd1) : angle;
        pi_r      = srs_pkg::PI_Q62 >> (62 - RED_FRAC);
        two_pi_r  = srs_pkg::PI_Q62 >> (61 - RED_FRAC);
        half_pi_r = srs_pkg::PI_Q62 >> (63 - RED_FRAC);
        xr = ({32'd0, mag} << 32) % two_pi_r;
        if (xr > pi_r)
        begin
            xr  = xr - pi_r;
            neg = !neg;
        end
        if (xr > half_pi_r)
            xr = pi_r - xr;
        x   = round_down({64'd0, xr}, RED_FRAC - WORK_FRAC);
        x2  = round_down({64'd0, x} * {64'd0, x}, WORK_FRAC);
        thr = {48'd0, thr_cfg} << (WORK_FRAC - OUT_FRAC);
        tm  = x;
        acc = signed'(x);
        positive = 1'b1;
        count = 1;
        while (count < MAX_TERMS && tm >= thr)
        begin
            nn = 64'(2 * count + 1);
            d  = nn * (nn - 64'd1);
            tm = round_down({64'd0, tm} * {64'd0, x2}, WORK_FRAC);
            tm = (tm + d / 64'd2) / d;
            positive = !positive;
            if (positive)
                acc = acc + $signed(tm);
            else
                acc = acc - $signed(tm);
            count++;
        end
        if (acc < 0)
            res = '0;
        else if (acc > (64'sd1 <<< WORK_FRAC))
            res = 64'd1 << WORK_FRAC;
        else
            res = acc;
        if (WORK_FRAC != OUT_FRAC)
            res = round_down({64'd0, res}, WORK_FRAC - OUT_FRAC);
        if (neg)
            res = ~res + 64'd1;
        w.sine      = res[31:0];
        w.terms     = count[4:0];
        w.limit_hit = tm >= thr;
        return w;
    endfunction

    task automatic write_threshold(logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srs_pkg::REG_TERM_THRESHOLD[2:0];
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        threshold = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_angle(logic [31:0] angle, logic known, sine_word_t result);
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sine_queue.push_back(known ? result : predict_sine(angle, threshold));
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 3) != 0)
            return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sine_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] random_angle();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0200_0000);
            2: return -$urandom_range(0, 32'h0200_0000);
            3: return 32'(longint'($urandom_range(0, 80)) * 64'd26353589);
            default: return $urandom_range(0, 32'h7FFF_FFFF)
                            ^ {1'($urandom_range(0, 1)), 31'd0};
        endcase
    endfunction

    function automatic stim_row_t row(logic [31:0] a, logic k, logic [31:0] s,
                                      logic [4:0] t, logic h);
        stim_row_t r;
        r.angle = a;
        r.known = k;
        r.result.sine = s;
        r.result.terms = t;
        r.result.limit_hit = h;
        return r;
    endfunction

    // sink: random stalls, one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 7) == 0)
            m_tready <= !m_tready;
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        sine_word_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[37:0];
            words_out++;
            if (sine_queue.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = sine_queue.pop_front();
                if (got.sine !== want.sine)
                begin
                    $display("%0t: sine_value expected %h actual %h", $time, want.sine, got.sine);
                    errors++;
                end
                if (got.terms !== want.terms)
                begin
                    $display("%0t: terms_used expected %0d actual %0d", $time, want.terms,
                             got.terms);
                    errors++;
                end
                if (got.limit_hit !== want.limit_hit)
                begin
                    $display("%0t: term_limit_hit expected %b actual %b", $time,
                             want.limit_hit, got.limit_hit);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d words outstanding", sine_queue.size());
            $display("sine_range_reduced_series_unit test failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] thr_set[5];
        int n_sent;
        errors = 0;
        words_out = 0;
        cycles = 0;
        hold_off = 1'b0;
        hold_off_len = 0;
        threshold = srs_pkg::THR_RESET;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero angle gives zero in one term; extremes left to the predictor
        directed.push_back(row(32'h0000_0000, 1'b1, 32'd0, 5'd1, 1'b0));
        directed.push_back(row(32'h8000_0000, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h0000_0001, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h0192_1FB5, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'hFE6D_E04B, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h0324_3F6A, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h04B6_5F1F, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h0648_7ED5, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h0648_7ED6, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'h5555_5555, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0));
        foreach (directed[i])
        begin
            send_angle(directed[i].angle, directed[i].known, directed[i].result);
            n_sent++;
        end
        drain();

        // zero threshold forces the full term count; huge one stops early above one
        thr_set = '{16'd0, 16'd65535, 16'd1, 16'd300, srs_pkg::THR_RESET};
        foreach (thr_set[p])
        begin
            write_threshold(thr_set[p]);
            send_angle(32'h0192_1FB5, 1'b0, '0);
            send_angle(32'h0150_0000, 1'b0, '0);
            send_angle(32'h8000_0000, 1'b0, '0);
            n_sent += 3;
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                sender_gap();
                send_angle(random_angle(), 1'b0, '0);
                n_sent++;
                // long sink hold-off while the source keeps pushing
                if (p == 1 && i == 20)
                begin
                    hold_off_len = 300;
                    hold_off = 1'b1;
                    fork
                    begin
                        repeat (hold_off_len) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    join_none
                end
            end
            drain();
        end

        repeat (LATENCY + 10) @(negedge clk);
        $display("sent %0d angles over %0d threshold settings, checked %0d words",
                 n_sent, 6, words_out);
        if (errors == 0 && sine_queue.size() == 0)
            $display("sine_range_reduced_series_unit test passed");
        else
            $display("sine_range_reduced_series_unit test failed");
        $finish;
    end

endmodule
